// ===== sv/idb_pkg.sv =====
// idb_pkg: shared types, sizes and operation/status codes for the indexed
// deque buffer. No dependencies; used by the cell, the top level and the checker.
package idb_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // stream word widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 40;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_INSERT     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  // what the row of cells does this cycle
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_WRITE  = 2'd1,   // load word at pos
    CMD_INSERT = 2'd2,   // cells above pos take left neighbor, pos loads word
    CMD_DELETE = 2'd3    // cells at or above pos take right neighbor
  } cmd_mode_t;

  typedef struct packed {
    cmd_mode_t mode;
    idx_t      pos;
    word_t     word;
  } cell_cmd_t;

endpackage

// ===== sv/idb_cell.sv =====
// idb_cell: one storage cell of the buffer row. Holds one word and, on the
// broadcast command, holds, loads or takes a neighbor's word. Uses idb_pkg.
module idb_cell (
  input  logic               clk,
  input  idb_pkg::idx_t      my_pos,
  input  idb_pkg::cell_cmd_t cmd,
  input  idb_pkg::word_t     left_word,
  input  idb_pkg::word_t     right_word,
  output idb_pkg::word_t     word
);

  idb_pkg::word_t word_next;

  always_comb begin
    word_next = word;
    case (cmd.mode)
      idb_pkg::CMD_WRITE: begin
        if (my_pos == cmd.pos) word_next = cmd.word;
      end
      idb_pkg::CMD_INSERT: begin
        if (my_pos == cmd.pos)     word_next = cmd.word;
        else if (my_pos > cmd.pos) word_next = left_word;
      end
      idb_pkg::CMD_DELETE: begin
        if (my_pos >= cmd.pos) word_next = right_word;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== sv/indexed_deque_buffer.sv =====
// indexed_deque_buffer: top level, a dense ordered list kept in a row of
// idb_cell cells with a count, a range-removal sequencer and an output skid.
// Depends on idb_pkg and idb_cell.
//
// Usage:
//   Slave channel (s_*) takes one operation word: s_tuser holds the op code,
//   s_tdata holds value, index and index_end. Master channel (m_*) returns
//   exactly one result word per operation: the word popped or read (zero
//   otherwise), the count after the operation and a status.
//   Result: the word is registered into the output register, or into the
//   skid register when the output register still holds a word.
//   Throughput: one operation per cycle while the skid register is empty,
//   for every op but a range removal. A removal of n entries shifts the cell
//   row left by one position per cycle, and no next operation is accepted
//   until those shifts are done. The removal's result is registered when
//   the removal is accepted.
//   Stall: a result word waits in the output register; one more result can
//   be taken into a skid register, after which s_tready drops until the
//   receiver takes a word.
//   Reset: count clears to zero and both output registers empty. The cell
//   contents are not cleared; only positions below the count are ever read.
module indexed_deque_buffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] value, [35:32] index, [39:36] index_end
  input  logic [idb_pkg::IN_DATA_W-1:0]  s_tdata,
  // [2:0] op
  input  logic [idb_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] value_out, [36:32] count, [38:37] status
  output logic [idb_pkg::OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SHIFT = 2'b10
  } state_t;

  state_t         state, state_next;
  idb_pkg::cnt_t  count, count_next;
  idb_pkg::cnt_t  shift_left, shift_left_next;   // removal steps still due
  idb_pkg::idx_t  shift_pos, shift_pos_next;

  logic                           skid_valid;
  logic [idb_pkg::OUT_DATA_W-1:0] skid_data;
  logic [idb_pkg::OUT_DATA_W-1:0] res_data;

  idb_pkg::cell_cmd_t cmd;
  idb_pkg::word_t     cell_word [idb_pkg::CAPACITY];

  // unpack the operation word
  idb_pkg::op_t   op;
  logic [31:0]    in_value;
  logic [3:0]     in_index;
  logic [3:0]     in_end;
  assign op       = idb_pkg::op_t'(s_tuser[2:0]);
  assign in_value = s_tdata[31:0];
  assign in_index = s_tdata[35:32];
  assign in_end   = s_tdata[39:36];

  logic accept, take;
  assign s_tready = (state == S_IDLE) && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;

  // operation decode, evaluated against the current count
  logic              full, empty, idx_in_range, end_past;
  idb_pkg::status_t  status;
  logic              rd_en;
  idb_pkg::idx_t     rd_addr;
  idb_pkg::word_t    rd_word;
  idb_pkg::cell_cmd_t op_cmd;
  idb_pkg::cnt_t     op_count;
  idb_pkg::cnt_t     span;
  logic [31:0]       value_out;

  assign full         = (count == idb_pkg::CAPACITY[idb_pkg::CNT_W-1:0]);
  assign empty        = (count == '0);
  assign idx_in_range = (32'(in_index) < 32'(count));
  assign end_past     = (32'(in_end) >= 32'(count));
  assign span         = idb_pkg::CNT_W'(32'(in_end) - 32'(in_index) + 32'd1);

  always_comb begin
    status      = idb_pkg::ST_OK;
    rd_en       = 1'b0;
    rd_addr     = '0;
    op_cmd.mode = idb_pkg::CMD_NONE;
    op_cmd.pos  = '0;
    op_cmd.word = idb_pkg::word_t'(in_value);
    op_count    = count;
    case (op)
      idb_pkg::OP_PUSH_BACK, idb_pkg::OP_PUSH_FRONT, idb_pkg::OP_INSERT: begin
        if (full) begin
          status = idb_pkg::ST_FULL;
        end else begin
          op_count = count + 1'b1;
          if (op == idb_pkg::OP_PUSH_FRONT) begin
            op_cmd.mode = idb_pkg::CMD_INSERT;
            op_cmd.pos  = '0;
          end else if (op == idb_pkg::OP_INSERT && idx_in_range) begin
            op_cmd.mode = idb_pkg::CMD_INSERT;
            op_cmd.pos  = idb_pkg::IDX_W'(in_index);
          end else begin
            // append at the back
            op_cmd.mode = idb_pkg::CMD_WRITE;
            op_cmd.pos  = count[idb_pkg::IDX_W-1:0];
          end
        end
      end
      idb_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = idb_pkg::ST_EMPTY;
        end else begin
          op_count = count - 1'b1;
          rd_en    = 1'b1;
          rd_addr  = op_count[idb_pkg::IDX_W-1:0];
        end
      end
      idb_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = idb_pkg::ST_EMPTY;
        end else begin
          op_count    = count - 1'b1;
          rd_en       = 1'b1;
          rd_addr     = '0;
          op_cmd.mode = idb_pkg::CMD_DELETE;
          op_cmd.pos  = '0;
        end
      end
      idb_pkg::OP_READ: begin
        if (!idx_in_range) begin
          status = idb_pkg::ST_BADIDX;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idb_pkg::IDX_W'(in_index);
        end
      end
      idb_pkg::OP_WRITE: begin
        if (!idx_in_range) begin
          status = idb_pkg::ST_BADIDX;
        end else begin
          op_cmd.mode = idb_pkg::CMD_WRITE;
          op_cmd.pos  = idb_pkg::IDX_W'(in_index);
        end
      end
      idb_pkg::OP_REMOVE: begin
        // reversed range: nothing changes, status ok
        if (in_end >= in_index) begin
          if (end_past) begin
            status = idb_pkg::ST_BADIDX;
          end else begin
            op_count    = count - span;
            op_cmd.mode = idb_pkg::CMD_DELETE;
            op_cmd.pos  = idb_pkg::IDX_W'(in_index);
          end
        end
      end
      default: status = idb_pkg::ST_OK;
    endcase
  end

  // single read port onto the cell row
  assign rd_word   = cell_word[rd_addr];
  assign value_out = rd_en ? 32'(rd_word) : 32'd0;
  assign res_data  = {1'b0, status, op_count, value_out};

  // removal sequencer and broadcast command
  always_comb begin
    state_next      = state;
    count_next      = count;
    shift_left_next = shift_left;
    shift_pos_next  = shift_pos;
    cmd.mode        = idb_pkg::CMD_NONE;
    cmd.pos         = '0;
    cmd.word        = op_cmd.word;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd        = op_cmd;
          count_next = op_count;
          if (op == idb_pkg::OP_REMOVE && op_cmd.mode == idb_pkg::CMD_DELETE &&
              span > idb_pkg::CNT_W'(1)) begin
            shift_left_next = span - 1'b1;
            shift_pos_next  = op_cmd.pos;
            state_next      = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // advance the removal by one position
        cmd.mode        = idb_pkg::CMD_DELETE;
        cmd.pos         = shift_pos;
        shift_left_next = shift_left - 1'b1;
        if (shift_left == idb_pkg::CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      shift_left <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      shift_left <= shift_left_next;
    end
    shift_pos <= shift_pos_next;
  end

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < idb_pkg::CAPACITY; i++) begin : g_cell
    idb_pkg::word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == idb_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    idb_cell u_cell (
      .clk        (clk),
      .my_pos     (idb_pkg::IDX_W'(i)),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i])
    );
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          m_tdata    <= skid_data;
          skid_valid <= 1'b0;
        end else if (accept) begin
          m_tdata <= res_data;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (accept) begin
        if (m_tvalid) begin
          skid_data  <= res_data;
          skid_valid <= 1'b1;
        end else begin
          m_tdata  <= res_data;
          m_tvalid <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/idb_checker.sv =====
// idb_checker: port-level assertions for indexed_deque_buffer, bound to the
// top level below. Uses idb_pkg for status codes and capacity.
module idb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [idb_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic [1:0]  st;
  logic [4:0]  cnt;
  assign st  = m_tdata[38:37];
  assign cnt = m_tdata[36:32];

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // no result is presented right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a failed operation returns a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st != idb_pkg::ST_OK) |-> m_tdata[31:0] == 32'd0)
    else $error("nonzero word with error status");

  // full status only at capacity, empty status only at zero
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == idb_pkg::ST_FULL) |-> 32'(cnt) == idb_pkg::CAPACITY)
    else $error("full status below capacity");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == idb_pkg::ST_EMPTY) |-> cnt == 5'd0)
    else $error("empty status with entries");

endmodule

bind indexed_deque_buffer idb_checker u_idb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/indexed_deque_buffer_tb.sv =====
// indexed_deque_buffer_tb: self-checking testbench for the indexed deque buffer.
// Drives operation words on s_*, predicts each result word and checks m_*.
// Depends on idb_pkg and the indexed_deque_buffer RTL.
module indexed_deque_buffer_tb;
  import idb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 250;   // per idling phase, three phases

  // expected result word fields
  typedef struct {
    word_t   value;
    cnt_t    count;
    status_t status;
  } deque_result_t;

  // random stream bias: grow the list, shrink it, or leave it to chance
  typedef enum {FILL_UP, DRAIN, MIXED} bias_t;

  // Shadow list plus the queue of result words still owed by the block.
  class deque_scoreboard;
    word_t         slots[CAPACITY];
    int            fill;
    int            peak_fill;
    int            errors;
    int            status_seen[4];
    deque_result_t pending_results[$];

    // Apply one accepted operation to the shadow list and queue its result.
    function void note_op(op_t op, word_t val, idx_t idx, idx_t iend);
      deque_result_t r;
      int            pos;
      int            span;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // insert at or past the end appends
            if (op == OP_PUSH_BACK) pos = fill;
            else if (op == OP_PUSH_FRONT) pos = 0;
            else pos = (int'(idx) >= fill) ? fill : int'(idx);
            for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            fill++;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.value = slots[fill];
          end
        end
        OP_POP_FRONT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = slots[0];
            for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
            fill--;
          end
        end
        OP_READ: begin
          if (int'(idx) >= fill) r.status = ST_BADIDX;
          else r.value = slots[idx];
        end
        OP_WRITE: begin
          if (int'(idx) >= fill) r.status = ST_BADIDX;
          else slots[idx] = val;
        end
        default: begin
          // range removal: reversed range is a no-op with status ok
          if (iend >= idx) begin
            if (int'(iend) >= fill) begin
              r.status = ST_BADIDX;
            end else begin
              span = int'(iend) - int'(idx) + 1;
              for (int i = int'(iend) + 1; i < fill; i++) slots[i-span] = slots[i];
              fill -= span;
            end
          end
        end
      endcase
      r.count = cnt_t'(fill);
      if (fill > peak_fill) peak_fill = fill;
      status_seen[r.status]++;
      pending_results.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(logic [OUT_DATA_W-1:0] d);
      deque_result_t r;
      word_t         got_value;
      cnt_t          got_count;
      status_t       got_status;
      got_value  = d[31:0];
      got_count  = d[36:32];
      got_status = status_t'(d[38:37]);
      if (pending_results.size() == 0) begin
        $error("unexpected result word: value_out %h count %0d status %0d",
               got_value, got_count, got_status);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (got_value !== r.value) begin
        $error("value_out mismatch: expected %h, actual %h", r.value, got_value);
        errors++;
      end
      if (got_count !== r.count) begin
        $error("count mismatch: expected %0d, actual %0d", r.count, got_count);
        errors++;
      end
      if (got_status !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, got_status);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] value, [35:32] index, [39:36] index_end
  logic [IN_USER_W-1:0]  s_tuser  = '0;   // [2:0] op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [31:0] value_out, [36:32] count, [38:37] status

  deque_scoreboard sb = new();
  int send_idle_pct = 11;
  int recv_idle_pct = 69;
  int ops_sent      = 0;
  int cycles        = 0;

  indexed_deque_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run here.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: sample the pre-edge handshake, check the word, then pick the
  // next cycle's tready. Stalls land on every phase of the block's work.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Present one operation word and hold it until the block takes it. tvalid
  // stays high across back-to-back words; only an idle gap lowers it.
  task automatic send_op(op_t op, word_t val, idx_t idx, idx_t iend);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {iend, idx, val};
    s_tuser  <= {{(IN_USER_W-3){1'b0}}, op};
    do @(posedge clk); while (!s_tready);
    sb.note_op(op, val, idx, iend);
    ops_sent++;
  endtask

  // Extremes of every field, every op, and the empty, bad index, reversed
  // range, range past the end and insert past the end cases.
  task automatic run_directed();
    send_op(OP_POP_BACK,   '0,           4'd0,  4'd0);   // pop on empty list
    send_op(OP_POP_FRONT,  '0,           4'd15, 4'd15);
    send_op(OP_READ,       '0,           4'd0,  4'd0);   // read on empty list
    send_op(OP_WRITE,      '1,           4'd15, 4'd0);
    send_op(OP_REMOVE,     '0,           4'd3,  4'd1);   // reversed range, empty
    send_op(OP_REMOVE,     '0,           4'd0,  4'd0);   // range past the end
    send_op(OP_PUSH_BACK,  '1,           4'd0,  4'd0);
    send_op(OP_PUSH_FRONT, '0,           4'd15, 4'd15);
    send_op(OP_INSERT,     32'hA5A5A5A5, 4'd15, 4'd0);   // insert past end appends
    send_op(OP_INSERT,     32'h5A5A5A5A, 4'd1,  4'd0);
    send_op(OP_INSERT,     32'h00000001, 4'd4,  4'd0);   // insert at end appends
    send_op(OP_READ,       '0,           4'd0,  4'd0);
    send_op(OP_READ,       '0,           4'd4,  4'd0);
    send_op(OP_READ,       '0,           4'd5,  4'd0);   // one past the end
    send_op(OP_WRITE,      32'h80000000, 4'd2,  4'd0);
    send_op(OP_READ,       '0,           4'd2,  4'd0);
    send_op(OP_REMOVE,     '0,           4'd1,  4'd2);
    send_op(OP_REMOVE,     '0,           4'd2,  4'd7);   // end past the count
    send_op(OP_REMOVE,     '0,           4'd2,  4'd1);   // reversed, non-empty
    send_op(OP_POP_FRONT,  '0,           4'd0,  4'd0);
    send_op(OP_POP_BACK,   '0,           4'd0,  4'd0);
    send_op(OP_REMOVE,     '0,           4'd0,  4'd0);   // remove the last entry
    send_op(OP_POP_BACK,   '0,           4'd0,  4'd0);
  endtask

  // Random words in 40-word segments that fill, drain or mix, so the list
  // swings between empty and full. Indexes mostly land inside the list.
  task automatic run_random(int n);
    bias_t bias;
    op_t   op;
    word_t val;
    idx_t  idx;
    idx_t  iend;
    int    fill;
    int    span_max;
    int    roll;
    for (int k = 0; k < n; k++) begin
      bias = bias_t'((k / 40) % 3);
      fill = sb.fill;
      roll = $urandom_range(99);
      op   = op_t'($urandom_range(7));
      case (bias)
        FILL_UP: begin
          if (roll < 70) begin
            case ($urandom_range(2))
              0:       op = OP_PUSH_BACK;
              1:       op = OP_PUSH_FRONT;
              default: op = OP_INSERT;
            endcase
          end
        end
        DRAIN: begin
          if (roll < 60) begin
            case ($urandom_range(2))
              0:       op = OP_POP_BACK;
              1:       op = OP_POP_FRONT;
              default: op = OP_REMOVE;
            endcase
          end
        end
        default: ;
      endcase
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      if (fill > 0 && $urandom_range(99) < 80) idx = idx_t'($urandom_range(fill - 1));
      else idx = idx_t'($urandom_range(15));
      iend = idx_t'($urandom_range(15));
      if (op == OP_REMOVE && int'(idx) < fill && $urandom_range(99) < 75) begin
        // short spans keep the block moving; a quarter may run up to the end
        span_max = fill - 1 - int'(idx);
        if ($urandom_range(3) == 0) iend = idx_t'($urandom_range(fill - 1, int'(idx)));
        else iend = idx_t'(int'(idx) + $urandom_range(span_max < 2 ? span_max : 2));
      end
      send_op(op, val, idx, iend);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalled
    run_directed();
    run_random(RANDOM_ITEMS);

    // swap: sender mostly idle, receiver mostly ready
    send_idle_pct = 69;
    recv_idle_pct = 11;
    run_random(RANDOM_ITEMS);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS);
    s_tvalid <= 1'b0;

    // drain, then allow for a trailing range removal and stray words
    while (sb.pending() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);

    $display("covered %0d operations in three idling phases, peak count %0d",
             ops_sent, sb.peak_fill);
    $display("statuses seen: ok %0d, empty %0d, full %0d, bad index %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FULL], sb.status_seen[ST_BADIDX]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/idb_pkg.sv
sv/idb_cell.sv
sv/indexed_deque_buffer.sv
sv/idb_checker.sv
sim/indexed_deque_buffer_tb.sv
